FILE: src/llce_pkg.sv
`timescale 1ns / 1ps

package llce_pkg;

	// Default sizing of the node pool
	localparam int NODE_COUNT_DEF = 256;
	localparam int VALUE_BITS_DEF = 32;

	// Operation codes carried in the func field
	typedef enum logic [3:0] {
		FN_DISPOSE   = 4'd0,
		FN_INS_FIRST = 4'd1,
		FN_FIRST     = 4'd2,
		FN_GET_FIRST = 4'd3,
		FN_DEL_FIRST = 4'd4,
		FN_DEL_AFTER = 4'd5,
		FN_INS_AFTER = 4'd6,
		FN_GET       = 4'd7,
		FN_SET       = 4'd8,
		FN_NEXT      = 4'd9,
		FN_IS_ACTIVE = 4'd10
	} func_t;

	// Operation transfer
	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] data;
	} op_item_t;

	// Result transfer
	typedef struct packed {
		logic signed [31:0] value;
		logic               value_valid;
		logic               error;
		logic               sticky_error;
		logic               active;
	} res_item_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DA_LINK,
		ST_DA_FREE,
		ST_IA_LINK,
		ST_IA_HOOK
	} fsm_state_t;

	// Which pointer addresses the node memory read
	typedef enum logic [1:0] {
		RD_FREE,
		RD_HEAD,
		RD_CUR,
		RD_LINK
	} rd_sel_t;

	// Datapath action for one cycle
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_DISPOSE,
		ACT_INS_FIRST,
		ACT_CUR_FIRST,
		ACT_GET_FIRST,
		ACT_DEL_FIRST,
		ACT_DA_KEEP,
		ACT_DA_LINK_CUR,
		ACT_DA_FREE,
		ACT_IA_TAKE,
		ACT_IA_LINK_N,
		ACT_IA_LINK_CUR,
		ACT_GET,
		ACT_SET,
		ACT_NEXT
	} act_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		act_t    act;
		logic    resp;
		logic    err;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic head_ok;
		logic cur_ok;
		logic take_ok;
		logic link_ok;
		logic out_free;
	} dp_status_t;

endpackage

FILE: src/llce_ctrl.sv
`timescale 1ns / 1ps

module llce_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	input  llce_pkg::op_item_t   op,
	output logic                 op_stall,
	input  llce_pkg::dp_status_t sts,
	output llce_pkg::ctl_t       ctl
);

	llce_pkg::fsm_state_t state_q, state_d;
	logic [3:0]           func_q;

	// Hold the state and the opcode of the operation in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llce_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == llce_pkg::ST_IDLE && op_valid) begin
			func_q <= op.func;
		end
	end

	assign op_stall = (state_q != llce_pkg::ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			llce_pkg::ST_IDLE: begin
				if (op_valid) state_d = llce_pkg::ST_EXEC;
			end
			llce_pkg::ST_EXEC: begin
				if (sts.out_free) begin
					state_d = llce_pkg::ST_IDLE;
					if (func_q == llce_pkg::FN_DEL_AFTER && sts.cur_ok && sts.link_ok) begin
						state_d = llce_pkg::ST_DA_LINK;
					end
					if (func_q == llce_pkg::FN_INS_AFTER && sts.cur_ok && sts.take_ok) begin
						state_d = llce_pkg::ST_IA_LINK;
					end
				end
			end
			llce_pkg::ST_DA_LINK: state_d = llce_pkg::ST_DA_FREE;
			llce_pkg::ST_DA_FREE: begin
				if (sts.out_free) state_d = llce_pkg::ST_IDLE;
			end
			llce_pkg::ST_IA_LINK: state_d = llce_pkg::ST_IA_HOOK;
			llce_pkg::ST_IA_HOOK: begin
				if (sts.out_free) state_d = llce_pkg::ST_IDLE;
			end
			default: state_d = llce_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		ctl        = '0;
		ctl.rd_sel = llce_pkg::RD_FREE;
		ctl.act    = llce_pkg::ACT_NONE;
		case (state_q)
			llce_pkg::ST_IDLE: begin
				// Start the node read for the incoming operation
				if (op_valid) begin
					ctl.load  = 1'b1;
					ctl.rd_en = 1'b1;
					case (op.func)
						llce_pkg::FN_INS_FIRST,
						llce_pkg::FN_INS_AFTER: ctl.rd_sel = llce_pkg::RD_FREE;
						llce_pkg::FN_GET_FIRST,
						llce_pkg::FN_DEL_FIRST: ctl.rd_sel = llce_pkg::RD_HEAD;
						default:                ctl.rd_sel = llce_pkg::RD_CUR;
					endcase
				end
			end
			llce_pkg::ST_EXEC: begin
				if (sts.out_free) begin
					ctl.resp = 1'b1;
					case (func_q)
						llce_pkg::FN_DISPOSE: ctl.act = llce_pkg::ACT_DISPOSE;
						llce_pkg::FN_INS_FIRST: begin
							if (sts.take_ok) ctl.act = llce_pkg::ACT_INS_FIRST;
							else             ctl.err = 1'b1;
						end
						llce_pkg::FN_FIRST: ctl.act = llce_pkg::ACT_CUR_FIRST;
						llce_pkg::FN_GET_FIRST: begin
							if (sts.head_ok) ctl.act = llce_pkg::ACT_GET_FIRST;
							else             ctl.err = 1'b1;
						end
						llce_pkg::FN_DEL_FIRST: begin
							if (sts.head_ok) ctl.act = llce_pkg::ACT_DEL_FIRST;
						end
						llce_pkg::FN_DEL_AFTER: begin
							// Keep the doomed node and fetch its successor
							if (sts.cur_ok && sts.link_ok) begin
								ctl.resp   = 1'b0;
								ctl.act    = llce_pkg::ACT_DA_KEEP;
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = llce_pkg::RD_LINK;
							end
						end
						llce_pkg::FN_INS_AFTER: begin
							if (sts.cur_ok) begin
								if (sts.take_ok) begin
									ctl.resp   = 1'b0;
									ctl.act    = llce_pkg::ACT_IA_TAKE;
									ctl.rd_en  = 1'b1;
									ctl.rd_sel = llce_pkg::RD_CUR;
								end else begin
									ctl.err = 1'b1;
								end
							end
						end
						llce_pkg::FN_GET: begin
							if (sts.cur_ok) ctl.act = llce_pkg::ACT_GET;
							else            ctl.err = 1'b1;
						end
						llce_pkg::FN_SET: begin
							if (sts.cur_ok) ctl.act = llce_pkg::ACT_SET;
						end
						llce_pkg::FN_NEXT: begin
							if (sts.cur_ok) ctl.act = llce_pkg::ACT_NEXT;
						end
						default: ctl.act = llce_pkg::ACT_NONE;
					endcase
				end
			end
			llce_pkg::ST_DA_LINK: ctl.act = llce_pkg::ACT_DA_LINK_CUR;
			llce_pkg::ST_DA_FREE: begin
				if (sts.out_free) begin
					ctl.act  = llce_pkg::ACT_DA_FREE;
					ctl.resp = 1'b1;
				end
			end
			llce_pkg::ST_IA_LINK: ctl.act = llce_pkg::ACT_IA_LINK_N;
			llce_pkg::ST_IA_HOOK: begin
				if (sts.out_free) begin
					ctl.act  = llce_pkg::ACT_IA_LINK_CUR;
					ctl.resp = 1'b1;
				end
			end
			default: ctl.act = llce_pkg::ACT_NONE;
		endcase
	end

endmodule

FILE: src/llce_datapath.sv
`timescale 1ns / 1ps

module llce_datapath #(
	parameter int NODE_COUNT = llce_pkg::NODE_COUNT_DEF,
	parameter int VALUE_BITS = llce_pkg::VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  llce_pkg::op_item_t   op,
	input  llce_pkg::ctl_t       ctl,
	output llce_pkg::dp_status_t sts,
	input  logic                 res_stall,
	output logic                 res_valid,
	output llce_pkg::res_item_t  res
);

	localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int PTR_W = $clog2(NODE_COUNT + 1);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

	// Node pool
	logic [PTR_W-1:0]             link_mem [NODE_COUNT];
	logic signed [VALUE_BITS-1:0] value_mem [NODE_COUNT];

	logic [PTR_W-1:0]             head_q, cur_q, free_q, fresh_q, tmp_q;
	logic [PTR_W-1:0]             head_d, cur_d, free_d, fresh_d, tmp_d;
	logic                         err_seen_q;
	logic signed [31:0]           data_q;
	logic [PTR_W-1:0]             rdl_q;
	logic signed [VALUE_BITS-1:0] rdv_q;
	logic                         out_valid_q;
	llce_pkg::res_item_t          out_q;

	logic [PTR_W-1:0]             rd_ptr, alloc_ptr, link_norm;
	logic                         free_ok, out_free;
	logic                         lw_en, vw_en;
	logic [PTR_W-1:0]             lw_ptr, vw_ptr, lw_data;
	logic signed [VALUE_BITS-1:0] vw_data;
	logic signed [31:0]           rd_val;
	logic                         rd_vv;

	function automatic logic [IDX_W-1:0] idx_of(input logic [PTR_W-1:0] p);
		return (p < NIL) ? p[IDX_W-1:0] : '0;
	endfunction

	function automatic logic [PTR_W-1:0] norm(input logic [PTR_W-1:0] p);
		return (p < NIL) ? p : NIL;
	endfunction

	// Status toward the controller
	assign free_ok   = (free_q < NIL);
	assign out_free  = !out_valid_q || !res_stall;
	assign link_norm = norm(rdl_q);
	assign alloc_ptr = free_ok ? free_q : fresh_q;

	assign sts.head_ok  = (head_q < NIL);
	assign sts.cur_ok   = (cur_q < NIL);
	assign sts.take_ok  = free_ok || (fresh_q < NIL);
	assign sts.link_ok  = (rdl_q < NIL);
	assign sts.out_free = out_free;

	// Select the read address
	always_comb begin
		case (ctl.rd_sel)
			llce_pkg::RD_FREE: rd_ptr = free_q;
			llce_pkg::RD_HEAD: rd_ptr = head_q;
			llce_pkg::RD_CUR:  rd_ptr = cur_q;
			llce_pkg::RD_LINK: rd_ptr = rdl_q;
			default:           rd_ptr = cur_q;
		endcase
	end

	// Apply the action: pointer updates, memory writes, read result
	always_comb begin
		head_d  = head_q;
		cur_d   = cur_q;
		free_d  = free_q;
		fresh_d = fresh_q;
		tmp_d   = tmp_q;
		lw_en   = 1'b0;
		lw_ptr  = cur_q;
		lw_data = free_q;
		vw_en   = 1'b0;
		vw_ptr  = cur_q;
		vw_data = VALUE_BITS'(data_q);
		rd_val  = '0;
		rd_vv   = 1'b0;
		case (ctl.act)
			llce_pkg::ACT_DISPOSE: begin
				head_d  = NIL;
				cur_d   = NIL;
				free_d  = NIL;
				fresh_d = '0;
			end
			llce_pkg::ACT_INS_FIRST, llce_pkg::ACT_IA_TAKE: begin
				// Take a node from the free list or the fresh counter
				if (free_ok) free_d = link_norm;
				else         fresh_d = fresh_q + 1'b1;
				vw_en  = 1'b1;
				vw_ptr = alloc_ptr;
				if (ctl.act == llce_pkg::ACT_INS_FIRST) begin
					lw_en   = 1'b1;
					lw_ptr  = alloc_ptr;
					lw_data = head_q;
					head_d  = alloc_ptr;
				end else begin
					tmp_d = alloc_ptr;
				end
			end
			llce_pkg::ACT_CUR_FIRST: cur_d = head_q;
			llce_pkg::ACT_GET_FIRST, llce_pkg::ACT_GET: begin
				rd_val = 32'(rdv_q);
				rd_vv  = 1'b1;
			end
			llce_pkg::ACT_DEL_FIRST: begin
				if (cur_q == head_q) cur_d = NIL;
				head_d  = link_norm;
				lw_en   = 1'b1;
				lw_ptr  = head_q;
				lw_data = free_q;
				free_d  = head_q;
			end
			llce_pkg::ACT_DA_KEEP: tmp_d = link_norm;
			llce_pkg::ACT_DA_LINK_CUR: begin
				lw_en   = 1'b1;
				lw_ptr  = cur_q;
				lw_data = link_norm;
			end
			llce_pkg::ACT_DA_FREE: begin
				lw_en   = 1'b1;
				lw_ptr  = tmp_q;
				lw_data = free_q;
				free_d  = tmp_q;
			end
			llce_pkg::ACT_IA_LINK_N: begin
				lw_en   = 1'b1;
				lw_ptr  = tmp_q;
				lw_data = link_norm;
			end
			llce_pkg::ACT_IA_LINK_CUR: begin
				lw_en   = 1'b1;
				lw_ptr  = cur_q;
				lw_data = tmp_q;
			end
			llce_pkg::ACT_SET: begin
				vw_en  = 1'b1;
				vw_ptr = cur_q;
			end
			llce_pkg::ACT_NEXT: cur_d = link_norm;
			default: head_d = head_q;
		endcase
	end

	// Hold list pointers and the sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= NIL;
			cur_q       <= NIL;
			free_q      <= NIL;
			fresh_q     <= '0;
			err_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			cur_q   <= cur_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			if (ctl.resp && ctl.err) err_seen_q <= 1'b1;
			if (ctl.resp)            out_valid_q <= 1'b1;
			else if (!res_stall)     out_valid_q <= 1'b0;
		end
	end

	// Capture operand, scratch pointer and result
	always_ff @(posedge clk) begin
		tmp_q <= tmp_d;
		if (ctl.load) data_q <= op.data;
		if (ctl.resp) begin
			out_q.value        <= rd_val;
			out_q.value_valid  <= rd_vv;
			out_q.error        <= ctl.err;
			out_q.sticky_error <= err_seen_q | ctl.err;
			out_q.active       <= (cur_d < NIL);
		end
	end

	// Node memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (lw_en) link_mem[idx_of(lw_ptr)] <= lw_data;
		if (ctl.rd_en) rdl_q <= link_mem[idx_of(rd_ptr)];
	end

	always_ff @(posedge clk) begin
		if (vw_en) value_mem[idx_of(vw_ptr)] <= vw_data;
		if (ctl.rd_en) rdv_q <= value_mem[idx_of(rd_ptr)];
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

`ifndef SYNTHESIS
	a_resp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.resp |-> out_free)
		else $error("result issued while output register is occupied");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_seen_q |=> err_seen_q)
		else $error("sticky error cleared");

	a_read_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.value_valid) |-> !out_q.error)
		else $error("read result flagged as error");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.resp |=> ((cur_q < NIL || cur_q == NIL) && fresh_q <= NIL
			&& (head_q < NIL || head_q == NIL)))
		else $error("list pointer out of range");
`endif

endmodule

FILE: src/linked_list_cursor_engine_unit.sv
`timescale 1ns / 1ps
// The result register loads in ST_EXEC after the operation transfer, or in ST_DA_FREE or
// ST_IA_HOOK for delete-after with a successor and insert-after that takes a node.
// No new operation is taken until the result register has loaded; those two cases pass
// through ST_DA_LINK or ST_IA_LINK, as each node memory has one write and one read.
// A stalled result holds the engine in ST_EXEC, ST_DA_FREE or ST_IA_HOOK until it frees up.
// Reset (arst_n low, asynchronous) empties the list and the pool; node memory is not cleared.

module linked_list_cursor_engine_unit #(
	parameter int NODE_COUNT = llce_pkg::NODE_COUNT_DEF,
	parameter int VALUE_BITS = llce_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_stall,
	input  llce_pkg::op_item_t  op,
	output logic                res_valid,
	input  logic                res_stall,
	output llce_pkg::res_item_t res
);

	llce_pkg::ctl_t       ctl;
	llce_pkg::dp_status_t sts;

	llce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_stall (op_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	llce_datapath #(
		.NODE_COUNT (NODE_COUNT),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.ctl       (ctl),
		.sts       (sts),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
